// File: rtl/dcp_pkg.sv
// Shared types and constants for the distance constraint projection block.
// Used by dcp_sqrt, dcp_div and distance_constraint_projection.
`default_nettype none

package dcp_pkg;

    localparam int COORD_W     = 31;
    localparam int ROOT_W      = 32;
    localparam int QUOT_W      = 32;
    localparam int RAD_W       = 64;
    localparam int DEN_W       = 34;

    localparam logic REG_TARGET    = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    typedef enum logic [1:0] {
        OUTCOME_ADJUSTED    = 2'd0,
        OUTCOME_EXACT       = 2'd1,
        OUTCOME_LOCKED      = 2'd2,
        OUTCOME_DEFAULT_DIR = 2'd3
    } outcome_t;

    // Context carried alongside the square root pipeline.
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic                      lock1;
        logic                      lock2;
        logic                      sdx;
        logic                      sdy;
        logic [31:0]               adx;
        logic [31:0]               ady;
    } geo_t;

    // Context carried alongside the divider pipeline.
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic                      lock1;
        logic                      lock2;
        outcome_t                  outcome;
        logic [31:0]               err_out;
        logic                      in_tol;
        logic                      neg_x;
        logic                      neg_y;
    } fix_t;

endpackage

`default_nettype wire

// File: rtl/dcp_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
// Depends on dcp_pkg; carries a geo_t context alongside each item.
`default_nettype none

module dcp_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [dcp_pkg::RAD_W-1:0]   in_rad,
    input  dcp_pkg::geo_t               in_geo,
    output logic                        out_valid,
    output logic [dcp_pkg::ROOT_W-1:0]  out_root,
    output dcp_pkg::geo_t               out_geo
);

    logic                        valid_reg [0:dcp_pkg::ROOT_W-1];
    logic [35:0]                 rem_reg   [0:dcp_pkg::ROOT_W-1];
    logic [dcp_pkg::ROOT_W-1:0]  root_reg  [0:dcp_pkg::ROOT_W-1];
    logic [dcp_pkg::RAD_W-1:0]   rad_reg   [0:dcp_pkg::ROOT_W-1];
    dcp_pkg::geo_t               geo_reg   [0:dcp_pkg::ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < dcp_pkg::ROOT_W; k++) begin : g_stage
            logic                        cur_valid;
            logic [35:0]                 cur_rem;
            logic [dcp_pkg::ROOT_W-1:0]  cur_root;
            logic [dcp_pkg::RAD_W-1:0]   cur_rad;
            dcp_pkg::geo_t               cur_geo;
            logic [35:0]                 shifted;
            logic [35:0]                 trial;
            logic                        fits;

            if (k == 0) begin : g_first
                assign cur_valid = in_valid;
                assign cur_rem   = '0;
                assign cur_root  = '0;
                assign cur_rad   = in_rad;
                assign cur_geo   = in_geo;
            end else begin : g_next
                assign cur_valid = valid_reg[k-1];
                assign cur_rem   = rem_reg[k-1];
                assign cur_root  = root_reg[k-1];
                assign cur_rad   = rad_reg[k-1];
                assign cur_geo   = geo_reg[k-1];
            end

            // bring down the next two radicand bits and try root*4+1
            assign shifted = {cur_rem[33:0], cur_rad[dcp_pkg::RAD_W-1 -: 2]};
            assign trial   = {2'b00, cur_root, 2'b01};
            assign fits    = (shifted >= trial);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= cur_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= fits ? (shifted - trial) : shifted;
                    root_reg[k] <= {cur_root[dcp_pkg::ROOT_W-2:0], fits};
                    rad_reg[k]  <= {cur_rad[dcp_pkg::RAD_W-3:0], 2'b00};
                    geo_reg[k]  <= cur_geo;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[dcp_pkg::ROOT_W-1];
    assign out_root  = root_reg[dcp_pkg::ROOT_W-1];
    assign out_geo   = geo_reg[dcp_pkg::ROOT_W-1];

endmodule

`default_nettype wire

// File: rtl/dcp_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on dcp_pkg; carries a fix_t context alongside each item.
`default_nettype none

module dcp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [63:0]                 num_x,
    input  logic [63:0]                 num_y,
    input  logic [dcp_pkg::DEN_W-1:0]   den,
    input  dcp_pkg::fix_t               in_fix,
    output logic                        out_valid,
    output logic [dcp_pkg::QUOT_W-1:0]  q_x,
    output logic [dcp_pkg::QUOT_W-1:0]  q_y,
    output dcp_pkg::fix_t               out_fix
);

    logic [63:0]                 num_in    [0:1];
    logic                        valid_reg [0:dcp_pkg::QUOT_W-1];
    logic [dcp_pkg::DEN_W-1:0]   den_reg   [0:dcp_pkg::QUOT_W-1];
    dcp_pkg::fix_t               fix_reg   [0:dcp_pkg::QUOT_W-1];
    logic [dcp_pkg::DEN_W-1:0]   rem_reg   [0:dcp_pkg::QUOT_W-1][0:1];
    logic [31:0]                 low_reg   [0:dcp_pkg::QUOT_W-1][0:1];
    logic [dcp_pkg::QUOT_W-1:0]  q_reg     [0:dcp_pkg::QUOT_W-1][0:1];

    assign num_in[0] = num_x;
    assign num_in[1] = num_y;

    genvar k, l;
    generate
        for (k = 0; k < dcp_pkg::QUOT_W; k++) begin : g_stage
            logic                        cur_valid;
            logic [dcp_pkg::DEN_W-1:0]   cur_den;
            dcp_pkg::fix_t               cur_fix;

            if (k == 0) begin : g_first
                assign cur_valid = in_valid;
                assign cur_den   = den;
                assign cur_fix   = in_fix;
            end else begin : g_next
                assign cur_valid = valid_reg[k-1];
                assign cur_den   = den_reg[k-1];
                assign cur_fix   = fix_reg[k-1];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= cur_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[k] <= cur_den;
                    fix_reg[k] <= cur_fix;
                end
            end

            for (l = 0; l < 2; l++) begin : g_lane
                logic [dcp_pkg::DEN_W-1:0]   cur_rem;
                logic [31:0]                 cur_low;
                logic [dcp_pkg::QUOT_W-1:0]  cur_q;
                logic [dcp_pkg::DEN_W:0]     shifted;
                logic [dcp_pkg::DEN_W:0]     diff;
                logic                        fits;

                if (k == 0) begin : g_first
                    // the upper half is below the divisor, so it seeds the remainder
                    assign cur_rem = {2'b00, num_in[l][63:32]};
                    assign cur_low = num_in[l][31:0];
                    assign cur_q   = '0;
                end else begin : g_next
                    assign cur_rem = rem_reg[k-1][l];
                    assign cur_low = low_reg[k-1][l];
                    assign cur_q   = q_reg[k-1][l];
                end

                assign shifted = {cur_rem, cur_low[31]};
                assign fits    = (shifted >= {1'b0, cur_den});
                assign diff    = shifted - {1'b0, cur_den};

                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[k][l] <= fits ? diff[dcp_pkg::DEN_W-1:0]
                                              : shifted[dcp_pkg::DEN_W-1:0];
                        low_reg[k][l] <= {cur_low[30:0], 1'b0};
                        q_reg[k][l]   <= {cur_q[dcp_pkg::QUOT_W-2:0], fits};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[dcp_pkg::QUOT_W-1];
    assign q_x       = q_reg[dcp_pkg::QUOT_W-1][0];
    assign q_y       = q_reg[dcp_pkg::QUOT_W-1][1];
    assign out_fix   = fix_reg[dcp_pkg::QUOT_W-1];

endmodule

`default_nettype wire

// File: rtl/distance_constraint_projection.sv
// Top level of the distance constraint projection pipeline.
// Depends on dcp_pkg, dcp_sqrt and dcp_div.
//
// Usage:
//   Input items (two Q15.16 points plus lock flags) arrive on the s_ stream,
//   corrected points, the distance error, the tolerance flag and the outcome
//   leave on the m_ stream, one result item per input item, in order.
//   target_distance (index 0) and tolerance (index 1) are written through the
//   cfg_wr_* port while no item is in flight; writes to other indexes drop.
// Pipeline and throughput:
//   An item passes the difference, square and sum registers, the square
//   root pipeline (one root bit per stage), the error and product registers,
//   the division pipeline (one quotient bit per stage) and the output
//   register. One item per cycle while the skid register is empty.
// Reset:
//   aresetn low clears all valid bits and both configuration registers.
// Stall:
//   The output register is backed by a one-item skid register. While the skid
//   register is full the whole pipeline holds and s_tready is low; nothing is
//   lost or repeated.
`default_nettype none

module distance_constraint_projection (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // first_x, first_y, second_x, second_y, zero fill
    input  logic [1:0]   s_tuser,   // first_locked, second_locked
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // new_first_x, new_first_y, new_second_x,
                                    // new_second_y, distance_error, zero fill
    output logic [2:0]   m_tuser,   // within_tolerance, outcome
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_index,
    input  logic [31:0]  cfg_wr_data
);

    typedef struct packed {
        logic [dcp_pkg::COORD_W-1:0] x1;
        logic [dcp_pkg::COORD_W-1:0] y1;
        logic [dcp_pkg::COORD_W-1:0] x2;
        logic [dcp_pkg::COORD_W-1:0] y2;
        logic [31:0]                 err_out;
        logic                        in_tol;
        dcp_pkg::outcome_t           outcome;
    } res_t;

    function automatic logic [dcp_pkg::COORD_W-1:0] sat_coord(input logic signed [33:0] v);
        logic [dcp_pkg::COORD_W-1:0] r;
        if (v > 34'sd1073741823) begin
            r = {1'b0, {(dcp_pkg::COORD_W-1){1'b1}}};
        end else if (v < -34'sd1073741824) begin
            r = {1'b1, {(dcp_pkg::COORD_W-1){1'b0}}};
        end else begin
            r = v[dcp_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    logic         en;
    logic [31:0]  target_reg;
    logic [31:0]  tol_reg;

    // front: difference, magnitude, squares and sum
    dcp_pkg::geo_t               in_geo;
    logic signed [31:0]          dx, dy;
    logic                        p1_valid_reg, p2_valid_reg, p3_valid_reg;
    dcp_pkg::geo_t               p1_geo_reg, p2_geo_reg, p3_geo_reg;
    logic [63:0]                 sq_x_reg, sq_y_reg, rad_reg;

    logic                        sq_valid;
    logic [dcp_pkg::ROOT_W-1:0]  span;
    dcp_pkg::geo_t               sq_geo;

    // error stage
    logic signed [32:0]          err;
    logic                        eneg;
    logic [31:0]                 aerr;
    logic [1:0]                  nfree;
    logic                        dist_zero;
    dcp_pkg::fix_t               e1_fix_next;
    logic [dcp_pkg::DEN_W-1:0]   den_next;
    logic                        e1_valid_reg, e2_valid_reg;
    dcp_pkg::fix_t               e1_fix_reg, e2_fix_reg;
    logic [31:0]                 e1_aerr_reg, e1_mx_reg, e1_my_reg;
    logic [dcp_pkg::DEN_W-1:0]   e1_den_reg, e2_den_reg;
    logic [63:0]                 e2_num_x_reg, e2_num_y_reg;

    logic                        dv_valid;
    logic [dcp_pkg::QUOT_W-1:0]  q_x, q_y;
    dcp_pkg::fix_t               dv_fix;

    // final stage
    logic signed [33:0]          sx, sy;
    logic                        move;
    res_t                        fin;
    res_t                        out_reg, skid_reg;
    logic                        out_valid_reg, skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            tol_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                dcp_pkg::REG_TARGET:    target_reg <= cfg_wr_data;
                dcp_pkg::REG_TOLERANCE: tol_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_geo.x1    = s_tdata[30:0];
        in_geo.y1    = s_tdata[61:31];
        in_geo.x2    = s_tdata[92:62];
        in_geo.y2    = s_tdata[123:93];
        in_geo.lock1 = s_tuser[0];
        in_geo.lock2 = s_tuser[1];
        dx = {in_geo.x2[30], in_geo.x2} - {in_geo.x1[30], in_geo.x1};
        dy = {in_geo.y2[30], in_geo.y2} - {in_geo.y1[30], in_geo.y1};
        in_geo.sdx = dx[31];
        in_geo.sdy = dy[31];
        in_geo.adx = dx[31] ? 32'(-dx) : 32'(dx);
        in_geo.ady = dy[31] ? 32'(-dy) : 32'(dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_tvalid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_geo_reg <= in_geo;
            sq_x_reg   <= p1_geo_reg.adx * p1_geo_reg.adx;
            sq_y_reg   <= p1_geo_reg.ady * p1_geo_reg.ady;
            p2_geo_reg <= p1_geo_reg;
            rad_reg    <= sq_x_reg + sq_y_reg;
            p3_geo_reg <= p2_geo_reg;
        end
    end

    dcp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p3_valid_reg),
        .in_rad    (rad_reg),
        .in_geo    (p3_geo_reg),
        .out_valid (sq_valid),
        .out_root  (span),
        .out_geo   (sq_geo)
    );

    always_comb begin
        err       = $signed({1'b0, span}) - $signed({1'b0, target_reg});
        eneg      = err[32];
        aerr      = eneg ? 32'(-err) : err[31:0];
        nfree     = {1'b0, !sq_geo.lock1} + {1'b0, !sq_geo.lock2};
        dist_zero = (span == '0);

        e1_fix_next.x1      = sq_geo.x1;
        e1_fix_next.y1      = sq_geo.y1;
        e1_fix_next.x2      = sq_geo.x2;
        e1_fix_next.y2      = sq_geo.y2;
        e1_fix_next.lock1   = sq_geo.lock1;
        e1_fix_next.lock2   = sq_geo.lock2;
        e1_fix_next.err_out = aerr;
        e1_fix_next.in_tol  = (aerr < tol_reg);
        e1_fix_next.neg_x   = dist_zero ? eneg : (eneg ^ sq_geo.sdx);
        e1_fix_next.neg_y   = eneg ^ sq_geo.sdy;

        if (err == '0) begin
            e1_fix_next.outcome = dcp_pkg::OUTCOME_EXACT;
        end else if (nfree == 2'd0) begin
            e1_fix_next.outcome = dcp_pkg::OUTCOME_LOCKED;
        end else if (dist_zero) begin
            e1_fix_next.outcome = dcp_pkg::OUTCOME_DEFAULT_DIR;
        end else begin
            e1_fix_next.outcome = dcp_pkg::OUTCOME_ADJUSTED;
        end

        // divisor is dist*2 with both points free, else dist; nfree alone for coincident points
        if (dist_zero) begin
            den_next = {{(dcp_pkg::DEN_W-2){1'b0}}, nfree};
        end else if (nfree == 2'd2) begin
            den_next = {1'b0, span, 1'b0};
        end else begin
            den_next = {2'b00, span};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
        end else if (en) begin
            e1_valid_reg <= sq_valid;
            e2_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_fix_reg   <= e1_fix_next;
            e1_aerr_reg  <= aerr;
            e1_mx_reg    <= dist_zero ? 32'd1 : sq_geo.adx;
            e1_my_reg    <= dist_zero ? 32'd0 : sq_geo.ady;
            e1_den_reg   <= den_next;
            e2_num_x_reg <= e1_aerr_reg * e1_mx_reg;
            e2_num_y_reg <= e1_aerr_reg * e1_my_reg;
            e2_den_reg   <= e1_den_reg;
            e2_fix_reg   <= e1_fix_reg;
        end
    end

    dcp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e2_valid_reg),
        .num_x     (e2_num_x_reg),
        .num_y     (e2_num_y_reg),
        .den       (e2_den_reg),
        .in_fix    (e2_fix_reg),
        .out_valid (dv_valid),
        .q_x       (q_x),
        .q_y       (q_y),
        .out_fix   (dv_fix)
    );

    always_comb begin
        sx   = dv_fix.neg_x ? -$signed({2'b00, q_x}) : $signed({2'b00, q_x});
        sy   = dv_fix.neg_y ? -$signed({2'b00, q_y}) : $signed({2'b00, q_y});
        move = (dv_fix.outcome == dcp_pkg::OUTCOME_ADJUSTED) ||
               (dv_fix.outcome == dcp_pkg::OUTCOME_DEFAULT_DIR);

        fin.x1      = dv_fix.x1;
        fin.y1      = dv_fix.y1;
        fin.x2      = dv_fix.x2;
        fin.y2      = dv_fix.y2;
        fin.err_out = dv_fix.err_out;
        fin.in_tol  = dv_fix.in_tol;
        fin.outcome = dv_fix.outcome;
        if (move && !dv_fix.lock1) begin
            fin.x1 = sat_coord($signed({{3{dv_fix.x1[30]}}, dv_fix.x1}) + sx);
            fin.y1 = sat_coord($signed({{3{dv_fix.y1[30]}}, dv_fix.y1}) + sy);
        end
        if (move && !dv_fix.lock2) begin
            fin.x2 = sat_coord($signed({{3{dv_fix.x2[30]}}, dv_fix.x2}) - sx);
            fin.y2 = sat_coord($signed({{3{dv_fix.y2[30]}}, dv_fix.y2}) - sy);
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (dv_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (dv_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_reg <= fin;
            end else begin
                out_reg <= fin;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.err_out, out_reg.y2, out_reg.x2,
                       out_reg.y1, out_reg.x1};
    assign m_tuser  = {out_reg.outcome, out_reg.in_tol};

endmodule

`default_nettype wire

// File: tb/tb_distance_constraint_projection.sv
// Testbench for distance_constraint_projection: directed and random point pairs,
// predicted in-bench and checked in order on the result stream.
// Depends on dcp_pkg and the RTL of the block.
`default_nettype none

module tb_distance_constraint_projection;
    timeunit 1ns;
    timeprecision 1ps;
    import dcp_pkg::*;

    localparam longint CMAX = 64'sd1073741823;
    localparam longint CMIN = -64'sd1073741824;
    localparam int LAT = 70;
    localparam int LIMIT = 2000000;

    typedef struct {
        logic [127:0] tdata;
        logic [1:0]   tuser;
    } pair_t;

    typedef struct {
        logic [159:0] tdata;
        logic [2:0]   tuser;
    } proj_t;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, m_tready = 0;
    logic s_tready, m_tvalid;
    logic [127:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic [159:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_wr_en = 0, cfg_wr_index = REG_TARGET;
    logic [31:0] cfg_wr_data = '0;

    distance_constraint_projection dut (.*);

    logic [31:0] target_q, tol_q;
    pair_t pending[$];
    proj_t projections[$];
    int mismatches = 0, cycles = 0;
    int burst = 0, gap = 0, stall = 0, hold_off = 0;
    bit drain_mode = 0;
    bit in_acc = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // accept is decided at the rising edge; the driver acts on it at the falling edge
    always @(posedge aclk) begin
        in_acc <= s_tvalid && s_tready;
    end

    function automatic longint sat31(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic proj_t project(pair_t p);
        proj_t o;
        longint x1, y1, x2, y2, dx, dy, err, sx, sy, nx1, ny1, nx2, ny2;
        longint unsigned adx, ady, span, aerr, eo, den, qx, qy;
        bit l1, l2, eneg;
        int nfree;
        outcome_t oc;
        x1 = longint'($signed(p.tdata[30:0]));
        y1 = longint'($signed(p.tdata[61:31]));
        x2 = longint'($signed(p.tdata[92:62]));
        y2 = longint'($signed(p.tdata[123:93]));
        l1 = p.tuser[0];
        l2 = p.tuser[1];
        dx = x2 - x1;
        dy = y2 - y1;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        span = root64(adx * adx + ady * ady);
        err = longint'(span) - longint'({32'd0, target_q});
        eneg = err < 0;
        aerr = eneg ? -err : err;
        eo = aerr > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : aerr;
        nfree = (l1 ? 0 : 1) + (l2 ? 0 : 1);
        nx1 = x1; ny1 = y1; nx2 = x2; ny2 = y2;
        if (err == 0) begin
            oc = OUTCOME_EXACT;
        end else if (nfree == 0) begin
            oc = OUTCOME_LOCKED;
        end else begin
            if (span == 0) begin
                qx = aerr / nfree;
                sx = eneg ? -longint'(qx) : longint'(qx);
                sy = 0;
                oc = OUTCOME_DEFAULT_DIR;
            end else begin
                den = span * nfree;
                qx = (aerr * adx) / den;
                qy = (aerr * ady) / den;
                sx = (eneg != (dx < 0)) ? -longint'(qx) : longint'(qx);
                sy = (eneg != (dy < 0)) ? -longint'(qy) : longint'(qy);
                oc = OUTCOME_ADJUSTED;
            end
            if (!l1) begin
                nx1 = x1 + sx; ny1 = y1 + sy;
            end
            if (!l2) begin
                nx2 = x2 - sx; ny2 = y2 - sy;
            end
        end
        o.tdata = {4'd0, eo[31:0], 31'(sat31(ny2)), 31'(sat31(nx2)),
                   31'(sat31(ny1)), 31'(sat31(nx1))};
        o.tuser = {oc, eo < {32'd0, tol_q}};
        return o;
    endfunction

    // Sender: bursts with gaps, optional pause until the block is empty.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_acc)) begin
            if (s_tvalid && in_acc) projections.push_back(project('{s_tdata, s_tuser}));
            if (pending.size() > 0 && !(drain_mode && projections.size() > 0) && gap == 0) begin
                pair_t p;
                p = pending.pop_front();
                s_tdata <= p.tdata;
                s_tuser <= p.tuser;
                s_tvalid <= 1;
                if (burst == 0) begin
                    burst = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst--;
                end
            end else begin
                s_tvalid <= 0;
                if (gap > 0) gap--;
            end
        end
    end

    // Receiver: random stall pattern plus one long hold-off in the second random phase.
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_tready <= 0;
        end else if (stall > 0) begin
            stall--;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
            if ($urandom_range(0, 15) == 0) stall = $urandom_range(1, 8);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (projections.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h %h", m_tdata, m_tuser);
            end else begin
                proj_t e;
                e = projections.pop_front();
                if (e.tdata !== m_tdata || e.tuser !== m_tuser) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h/%h got %h/%h",
                                 e.tdata, e.tuser, m_tdata, m_tuser);
                end
            end
        end
    end

    function automatic logic [30:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 31'h3FFFFFFF;
            1: return 31'h40000000;
            2: return 31'($urandom_range(0, 1 << 20)) - 31'd524288;
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic add_pair(logic [30:0] x1, y1, x2, y2, logic [1:0] lk);
        pair_t p;
        p.tdata = {4'd0, y2, x2, y1, x1};
        p.tuser = lk;
        pending.push_back(p);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 0;
        if (idx == REG_TARGET) target_q = val;
        else tol_q = val;
    endtask

    task automatic wait_drain();
        while (pending.size() > 0 || s_tvalid || projections.size() > 0) @(posedge aclk);
        repeat (LAT + 5) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] targets[4];
        logic [31:0] tols[4];
        logic [30:0] a, b;
        target_q = 0;
        tol_q = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: exact, coincident, locked, extremes.
        add_pair(0, 0, 0, 0, 2'b00);
        add_pair(5, 5, 5, 5, 2'b11);
        wait_drain();
        write_reg(REG_TARGET, 32'h0001_0000);
        write_reg(REG_TOLERANCE, 32'h0000_8000);
        add_pair(0, 0, 31'h10000, 0, 2'b00);
        add_pair(7, 7, 7, 7, 2'b00);
        add_pair(7, 7, 7, 7, 2'b01);
        add_pair(7, 7, 7, 7, 2'b10);
        add_pair(0, 0, 31'h30000, 31'h40000, 2'b00);
        add_pair(0, 0, 31'h30000, 31'h40000, 2'b11);
        add_pair(31'h3FFFFFFF, 31'h3FFFFFFF, 31'h40000000, 31'h40000000, 2'b00);
        add_pair(31'h40000000, 31'h40000000, 31'h3FFFFFFF, 31'h3FFFFFFF, 2'b01);
        add_pair(31'h40000000, 0, 31'h3FFFFFFF, 0, 2'b10);
        add_pair(31'h3FFFFFFF, 31'h40000000, 31'h3FFFFFFF, 31'h40000000, 2'b00);
        wait_drain();
        write_reg(REG_TARGET, 32'hFFFF_FFFF);
        write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
        add_pair(0, 0, 0, 0, 2'b00);
        add_pair(31'h40000000, 31'h40000000, 31'h3FFFFFFF, 31'h3FFFFFFF, 2'b00);
        add_pair(1, 2, 3, 4, 2'b01);
        wait_drain();

        targets = '{32'd0, 32'h0010_0000, 32'h4000_0000, 32'hFFFF_FFFF};
        tols = '{32'd0, 32'h0000_1000, 32'h0100_0000, 32'hFFFF_FFFF};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_TARGET, ph < 4 ? targets[ph] : $urandom());
            write_reg(REG_TOLERANCE, ph < 4 ? tols[$urandom_range(0, 3)] : $urandom());
            for (int i = 0; i < 250; i++) begin
                a = rand_coord();
                b = rand_coord();
                // Occasionally hit the target distance exactly along x, when the target is below 2^30.
                if ($urandom_range(0, 9) == 0)
                    add_pair(0, b, 31'(target_q & 32'h3FFFFFFF), b, 2'($urandom()));
                else if ($urandom_range(0, 19) == 0)
                    add_pair(a, b, a, b, 2'($urandom()));
                else
                    add_pair(a, b, rand_coord(), rand_coord(), 2'($urandom()));
            end
            if (ph == 1) begin
                repeat (20) @(posedge aclk);
                hold_off = 300;
            end
            if (ph == 2) begin
                repeat (100) @(posedge aclk);
                drain_mode = 1;
                repeat (200) @(posedge aclk);
                drain_mode = 0;
            end
            wait_drain();
        end

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
